### rtl/icph_pkg.sv
// Shared types, kind codes and constants for the internet checksum block.
// No dependencies; used by every module under rtl.
package icph_pkg;

   localparam int WORD_BITS = 16;
   localparam int COUNT_BITS_DEF = 16;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [7:0]           byte_type;
   typedef logic [1:0]           kind_type;

   localparam kind_type KIND_IP  = 2'd0;
   localparam kind_type KIND_UDP = 2'd1;
   localparam kind_type KIND_TCP = 2'd2;

   localparam word_type PROTO_UDP  = 16'd17;
   localparam word_type PROTO_TCP  = 16'd6;
   localparam word_type LEN_OFFSET = 16'd8;

   // One accepted byte as held in the input register.
   typedef struct packed {
      byte_type data_byte;
      logic     last_byte;
      kind_type kind;
   } item_type;

endpackage

### rtl/icph_in_stage.sv
// Input register of the checksum block: captures one beat per cycle while it is empty or its held beat is taken.
// Depends on icph_pkg.
module icph_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  icph_pkg::item_type req_item,
   input  logic              take,
   output logic              held_valid,
   output icph_pkg::item_type held_item
);

   logic               valid_ff, valid_in;
   icph_pkg::item_type item_ff, item_in;
   logic               fire;

   assign req_tready = !valid_ff || take;
   assign fire       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (fire) begin
         valid_in = 1'b1;
         item_in  = req_item;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign held_valid = valid_ff;
   assign held_item  = item_ff;

   // A held beat that is not taken stays put.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !take |=> valid_ff && $stable(item_ff))
      else $error("input register lost or changed a held beat");

   // An accepted beat is held in the next cycle.
   a_fill: assert property (@(posedge clock) disable iff (reset)
      fire |=> valid_ff)
      else $error("accepted beat not held");

endmodule

### rtl/icph_sum.sv
// Running ones' complement sum, pseudo-header completion and result register.
// Depends on icph_pkg.
module icph_sum #(
   parameter int COUNT_BITS = icph_pkg::COUNT_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               held_valid,
   input  icph_pkg::item_type held_item,
   output logic               take,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output icph_pkg::word_type rsp_checksum
);

   icph_pkg::word_type acc_ff, acc_in;
   logic               odd_ff, odd_in;
   logic [COUNT_BITS-1:0] count_ff, count_in, count_next;
   logic               out_valid_ff, out_valid_in;
   icph_pkg::word_type checksum_ff, checksum_in;

   icph_pkg::word_type word;
   icph_pkg::word_type proto;
   icph_pkg::word_type len;
   logic [16:0]        run_sum;
   icph_pkg::word_type run_fold;
   logic [17:0]        total;
   logic [16:0]        fold1;
   icph_pkg::word_type fold2;
   logic               out_free;
   logic               is_last;

   assign out_free = !out_valid_ff || rsp_tready;
   assign is_last  = held_item.last_byte;
   // Advance a non-final byte always; a final byte only when the result slot frees.
   assign take     = held_valid && (!is_last || out_free);

   // Pair bytes big-endian: even positions go high.
   assign word = odd_ff ? {8'h00, held_item.data_byte} : {held_item.data_byte, 8'h00};

   assign count_next = count_ff + 1'b1;
   assign len        = icph_pkg::word_type'(count_next) - icph_pkg::LEN_OFFSET;

   always_comb begin
      unique case (held_item.kind)
         icph_pkg::KIND_UDP: proto = icph_pkg::PROTO_UDP;
         icph_pkg::KIND_TCP: proto = icph_pkg::PROTO_TCP;
         default:            proto = '0;
      endcase
   end

   assign run_sum  = {1'b0, acc_ff} + {1'b0, word};
   assign run_fold = run_sum[15:0] + {15'd0, run_sum[16]};

   // Four-operand sum folded twice equals the chain of end-around adds.
   assign total = {2'b00, acc_ff} + {2'b00, word}
                + ((proto != '0) ? {2'b00, proto} + {2'b00, len} : 18'd0);
   assign fold1 = {1'b0, total[15:0]} + {15'd0, total[17:16]};
   assign fold2 = fold1[15:0] + {15'd0, fold1[16]};

   always_comb begin
      acc_in       = acc_ff;
      odd_in       = odd_ff;
      count_in     = count_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      checksum_in  = checksum_ff;
      if (take) begin
         if (is_last) begin
            acc_in       = '0;
            odd_in       = 1'b0;
            count_in     = '0;
            out_valid_in = 1'b1;
            checksum_in  = ~fold2;
         end else begin
            acc_in   = run_fold;
            odd_in   = !odd_ff;
            count_in = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         odd_ff       <= 1'b0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         odd_ff       <= odd_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      checksum_ff <= checksum_in;
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_checksum = checksum_ff;

   // A final byte never overwrites a result that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      take && is_last |-> !out_valid_ff || rsp_tready)
      else $error("final byte taken while result slot busy");

   // A final byte shows a result in the next cycle.
   a_result: assert property (@(posedge clock) disable iff (reset)
      take && is_last |=> out_valid_ff)
      else $error("final byte gave no result");

   // A final byte clears the running state.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      take && is_last |=> acc_ff == '0 && !odd_ff && count_ff == '0)
      else $error("running state not cleared after final byte");

endmodule

### rtl/internet_checksum_pseudo_header.sv
// Internet checksum with UDP/TCP pseudo-header completion, one byte per beat.
// A final byte's checksum reaches rsp via the input register, then the result register.
// 1 byte per cycle unless a final byte waits; the running sum is one 16-bit end-around add.
// A waiting result stalls only a final byte; the bytes behind that final byte wait with it.
// Reset (synchronous, active high) clears sum, byte position, count, valids.
module internet_checksum_pseudo_header #(
   parameter int COUNT_BITS = icph_pkg::COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   input  logic [1:0]  req_tuser,   // [1:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [15:0] checksum
);

   icph_pkg::item_type req_item;
   icph_pkg::item_type held_item;
   logic               held_valid;
   logic               take;

   // Gather the beat's fields into one item.
   assign req_item.data_byte = req_tdata;
   assign req_item.last_byte = req_tlast;
   assign req_item.kind      = req_tuser;

   // Input register: hold one beat until the sum stage takes it.
   icph_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .take       (take),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   // Sum stage: advance the running sum, or on a final byte add its word and,
   // for UDP or TCP, the pseudo-header words, then fold and load the result register.
   icph_sum #(
      .COUNT_BITS (COUNT_BITS)
   ) u_sum (
      .clock        (clock),
      .reset        (reset),
      .held_valid   (held_valid),
      .held_item    (held_item),
      .take         (take),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_checksum (rsp_tdata)
   );

endmodule
